/* rtl/core/swpr_pkg.sv */
// package: packet codes, response codes and size constants for the stop-and-wait receiver
package swpr_pkg;

	localparam int MAX_PAYLOAD       = 1024;
	localparam int MAX_MESSAGE_BYTES = 1048575;

	localparam int POS_W = $clog2(MAX_PAYLOAD + 1);
	localparam int LEN_W = $clog2(MAX_MESSAGE_BYTES + 1);
	localparam int SUM_W = 32;

	typedef enum logic [2:0] {
		PKT_DATA      = 3'd0,
		PKT_LAST_DATA = 3'd1,
		PKT_ACK       = 3'd2,
		PKT_NACK      = 3'd3,
		PKT_TERM      = 3'd4
	} pkt_type_t;

	typedef enum logic [1:0] {
		RSP_NONE = 2'd0,
		RSP_ACK  = 2'd1,
		RSP_NACK = 2'd2
	} response_t;

endpackage

/* rtl/core/swpr_pkt_if.sv */
// interface: received packet item channel
interface swpr_pkt_if;
	logic               valid;
	logic               ready;
	logic [2:0]         pkt_type;
	logic               has_byte;
	logic signed [7:0]  byte_value;
	logic               end_of_packet;
	logic signed [31:0] rx_checksum;

	modport source (
		output valid, pkt_type, has_byte, byte_value, end_of_packet, rx_checksum,
		input  ready
	);
	modport sink (
		input  valid, pkt_type, has_byte, byte_value, end_of_packet, rx_checksum,
		output ready
	);
endinterface

/* rtl/core/swpr_rsp_if.sv */
// interface: per-item response channel
interface swpr_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  response;
	logic        commit;
	logic        message_done;
	logic [19:0] message_length;
	logic        ack_notify;
	logic        ack_value;
	logic        link_alive;

	modport source (
		output valid, response, commit, message_done, message_length, ack_notify,
			ack_value, link_alive,
		input  ready
	);
	modport sink (
		input  valid, response, commit, message_done, message_length, ack_notify,
			ack_value, link_alive,
		output ready
	);
endinterface

/* rtl/core/stop_and_wait_packet_receiver_core.sv */
// top level: stop-and-wait receiver, weighted checksum check and message length tracking
//
//   channel  dir  handshake     payload
//   pkt      in   valid/ready   pkt_type, has_byte, byte_value, end_of_packet, rx_checksum
//   rsp      out  valid/ready   response, commit, message_done, message_length,
//                               ack_notify, ack_value, link_alive
//
// one transaction in, one transaction out; a new item can be taken every cycle while rsp is not stalled
// an item passes from the input register through one pass of multiply-accumulate,
// checksum compare and length update into the result register
// arst_n clears the packet state and message length and brings the link up
// a stalled rsp holds the result register; pkt stays ready while the input
// register is empty or moves into the result register in the same cycle
module stop_and_wait_packet_receiver_core (
	input  logic        clk,
	input  logic        arst_n,
	swpr_pkt_if.sink    pkt,
	swpr_rsp_if.source  rsp
);
	import swpr_pkg::*;

	localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_PAYLOAD);
	localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_MESSAGE_BYTES);

	// input register
	logic               valid_s1;
	logic [2:0]         type_s1;
	logic               has_byte_s1;
	logic signed [7:0]  byte_s1;
	logic               eop_s1;
	logic [SUM_W-1:0]   rx_s1;

	// packet and link state
	logic [SUM_W-1:0]   sum_q;
	logic [POS_W-1:0]   pos_q;
	logic [LEN_W-1:0]   msg_q;
	logic               overlong_q;
	logic               alive_q;

	// result register
	logic               out_valid_q;
	response_t          response_q;
	logic               commit_q;
	logic               done_q;
	logic [LEN_W-1:0]   length_q;
	logic               notify_q;
	logic               ackv_q;
	logic               link_q;

	logic               advance;
	logic               take;

	logic signed [POS_W+8:0] prod;
	logic [SUM_W-1:0]   term;
	logic [SUM_W-1:0]   sum_upd;
	logic [POS_W-1:0]   pos_upd;
	logic               ovl_upd;
	logic [LEN_W:0]     len_sum;
	logic [LEN_W-1:0]   len_sat;

	logic [SUM_W-1:0]   sum_n;
	logic [POS_W-1:0]   pos_n;
	logic [LEN_W-1:0]   msg_n;
	logic               overlong_n;
	logic               alive_n;
	response_t          response_n;
	logic               commit_n;
	logic               done_n;
	logic [LEN_W-1:0]   length_n;
	logic               notify_n;
	logic               ackv_n;

	assign advance   = valid_s1 && (!out_valid_q || rsp.ready);
	assign pkt.ready = !valid_s1 || advance;
	assign take      = pkt.valid && pkt.ready;

	// odd positions weight the byte by its position, even ones add it plain
	assign prod = (POS_W + 9)'(byte_s1) * (POS_W + 9)'(signed'({1'b0, pos_q}));
	assign term = pos_q[0] ? SUM_W'(prod) : SUM_W'(byte_s1);

	always_comb begin
		sum_upd = sum_q;
		pos_upd = pos_q;
		ovl_upd = overlong_q;
		if (has_byte_s1) begin
			if (pos_q < POS_MAX) begin
				sum_upd = sum_q + term;
				pos_upd = pos_q + POS_W'(1);
			end else begin
				ovl_upd = 1'b1;
			end
		end
	end

	assign len_sum = {1'b0, msg_q} + (LEN_W + 1)'(pos_upd);
	assign len_sat = (len_sum >= {1'b0, LEN_MAX}) ? LEN_MAX : len_sum[LEN_W-1:0];

	always_comb begin
		sum_n      = sum_q;
		pos_n      = pos_q;
		overlong_n = overlong_q;
		msg_n      = msg_q;
		alive_n    = alive_q;
		response_n = RSP_NONE;
		commit_n   = 1'b0;
		done_n     = 1'b0;
		notify_n   = 1'b0;
		ackv_n     = 1'b0;
		if (alive_q) begin
			if (type_s1 == PKT_TERM) begin
				alive_n    = 1'b0;
				sum_n      = '0;
				pos_n      = '0;
				overlong_n = 1'b0;
			end else if (type_s1 == PKT_DATA || type_s1 == PKT_LAST_DATA) begin
				sum_n      = sum_upd;
				pos_n      = pos_upd;
				overlong_n = ovl_upd;
				if (eop_s1) begin
					if (!ovl_upd && sum_upd == rx_s1) begin
						response_n = RSP_ACK;
						commit_n   = 1'b1;
						msg_n      = len_sat;
						done_n     = (type_s1 == PKT_LAST_DATA);
					end else begin
						response_n = RSP_NACK;
					end
					sum_n      = '0;
					pos_n      = '0;
					overlong_n = 1'b0;
				end
			end else if (type_s1 == PKT_ACK || type_s1 == PKT_NACK) begin
				if (eop_s1) begin
					notify_n   = 1'b1;
					ackv_n     = (type_s1 == PKT_ACK);
					sum_n      = '0;
					pos_n      = '0;
					overlong_n = 1'b0;
				end
			end else if (eop_s1) begin
				sum_n      = '0;
				pos_n      = '0;
				overlong_n = 1'b0;
			end
		end
		// completed message reports its final length, then restarts
		length_n = msg_n;
		if (done_n) begin
			msg_n = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			type_s1     <= pkt.pkt_type;
			has_byte_s1 <= pkt.has_byte;
			byte_s1     <= pkt.byte_value;
			eop_s1      <= pkt.end_of_packet;
			rx_s1       <= pkt.rx_checksum;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q       <= '0;
			pos_q       <= '0;
			msg_q       <= '0;
			overlong_q  <= 1'b0;
			alive_q     <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				sum_q       <= sum_n;
				pos_q       <= pos_n;
				msg_q       <= msg_n;
				overlong_q  <= overlong_n;
				alive_q     <= alive_n;
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			response_q <= response_n;
			commit_q   <= commit_n;
			done_q     <= done_n;
			length_q   <= length_n;
			notify_q   <= notify_n;
			ackv_q     <= ackv_n;
			link_q     <= alive_n;
		end
	end

	assign rsp.valid          = out_valid_q;
	assign rsp.response       = response_q;
	assign rsp.commit         = commit_q;
	assign rsp.message_done   = done_q;
	assign rsp.message_length = length_q;
	assign rsp.ack_notify     = notify_q;
	assign rsp.ack_value      = ackv_q;
	assign rsp.link_alive     = link_q;

	// a dead link never comes back without reset
	a_link_stays_down: assert property (@(posedge clk) disable iff (!arst_n)
		!alive_q |=> !alive_q)
		else $error("link came back up without reset");

	// results from a dead link carry nothing
	a_dead_result_empty: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.link_alive |->
			rsp.response == RSP_NONE && !rsp.commit && !rsp.message_done && !rsp.ack_notify)
		else $error("dead link produced a response");

	// message completion only on an acknowledged, committed packet
	a_done_needs_ack: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.message_done |-> rsp.commit && rsp.response == RSP_ACK)
		else $error("message done without ack");

	// byte position never runs past the payload bound
	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= POS_MAX)
		else $error("byte position past payload bound");

endmodule

/* verif/tb.sv */
// testbench: checks the stop-and-wait receiver core item by item against its own model
`timescale 1ns / 100ps

module tb;
	import swpr_pkg::*;

	localparam logic [2:0] PKT_RSVD_FIRST = 3'd5;
	localparam logic [2:0] PKT_RSVD_LAST  = 3'd7;
	localparam int RANDOM_ITEMS = 1650;

	typedef struct {
		logic [2:0]  ptype;
		bit          has_byte;
		logic [7:0]  value;
		bit          eop;
		logic [31:0] rx;
	} pkt_item_t;

	typedef struct {
		response_t   resp;
		bit          commit;
		bit          done;
		logic [19:0] length;
		bit          notify;
		bit          ackv;
		bit          alive;
	} rsp_item_t;

	logic clk = 1'b0;
	logic arst_n;

	swpr_pkt_if pkt_ch ();
	swpr_rsp_if rsp_ch ();

	stop_and_wait_packet_receiver_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.pkt    (pkt_ch),
		.rsp    (rsp_ch)
	);

	always #1 clk = ~clk;

	pkt_item_t outgoing_items[$];
	rsp_item_t due_responses[$];

	// receiver state as the model sees it
	logic [31:0] rx_sum;
	logic [10:0] rx_pos;
	logic [19:0] msg_bytes;
	bit          pkt_overlong;
	bit          link_up;

	// stimulus side tracking of the packet checksum
	logic [31:0] gen_sum;
	logic [10:0] gen_pos;

	int errors;
	int items_in;
	int n_ack, n_nack, n_done, n_notify, n_overlong;
	int cyc;
	bit hold_rsp;
	int send_gap;
	int rsp_stall;
	bit rsp_ready_next;
	pkt_item_t drv_item;
	pkt_item_t seen_item;
	rsp_item_t want;

	always @(posedge clk) cyc <= cyc + 1;

	function automatic logic [31:0] weigh_byte(logic [31:0] sum, logic [10:0] at,
		logic [7:0] b);
		logic [31:0] sb;
		sb = {{24{b[7]}}, b};
		return at[0] ? sum + sb * {21'd0, at} : sum + sb;
	endfunction

	// mostly short gaps, a few long ones, and quiet stretches with none
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (hold_rsp || (cyc % 600) < 120 || r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	task automatic clear_packet();
		rx_sum = '0;
		rx_pos = '0;
		pkt_overlong = 1'b0;
	endtask

	task automatic apply_packet_item(input pkt_item_t it);
		rsp_item_t r;
		logic [19:0] room;
		r.resp = RSP_NONE;
		r.commit = 1'b0;
		r.done = 1'b0;
		r.notify = 1'b0;
		r.ackv = 1'b0;
		if (link_up) begin
			if (it.ptype == PKT_TERM) begin
				link_up = 1'b0;
				clear_packet();
			end else if (it.ptype <= PKT_LAST_DATA) begin
				if (it.has_byte) begin
					if (rx_pos < MAX_PAYLOAD) begin
						rx_sum = weigh_byte(rx_sum, rx_pos, it.value);
						rx_pos++;
					end else begin
						pkt_overlong = 1'b1;
					end
				end
				if (it.eop) begin
					if (!pkt_overlong && rx_sum == it.rx) begin
						r.resp = RSP_ACK;
						r.commit = 1'b1;
						room = 20'(MAX_MESSAGE_BYTES) - msg_bytes;
						if ({9'd0, rx_pos} >= room)
							msg_bytes = 20'(MAX_MESSAGE_BYTES);
						else
							msg_bytes = msg_bytes + {9'd0, rx_pos};
						if (it.ptype == PKT_LAST_DATA)
							r.done = 1'b1;
						n_ack++;
					end else begin
						r.resp = RSP_NACK;
						n_nack++;
						if (pkt_overlong)
							n_overlong++;
					end
					clear_packet();
				end
			end else if (it.ptype <= PKT_NACK) begin
				if (it.eop) begin
					r.notify = 1'b1;
					r.ackv = (it.ptype == PKT_ACK);
					n_notify++;
					clear_packet();
				end
			end else if (it.eop) begin
				clear_packet();
			end
		end
		r.length = msg_bytes;
		if (r.done) begin
			msg_bytes = '0;
			n_done++;
		end
		r.alive = link_up;
		due_responses.push_back(r);
	endtask

	// with use_sum the checksum is the packet's true sum xor rx
	task automatic queue_item(input logic [2:0] kind, input bit has_b, input logic [7:0] v,
		input bit eop, input logic [31:0] rx, input bit use_sum);
		pkt_item_t it;
		if (kind <= PKT_LAST_DATA && has_b && gen_pos < MAX_PAYLOAD) begin
			gen_sum = weigh_byte(gen_sum, gen_pos, v);
			gen_pos++;
		end
		it.ptype = kind;
		it.has_byte = has_b;
		it.value = v;
		it.eop = eop;
		it.rx = use_sum ? gen_sum ^ rx : rx;
		if (eop || kind == PKT_TERM) begin
			gen_sum = '0;
			gen_pos = '0;
		end
		outgoing_items.push_back(it);
	endtask

	// tidy packets carry a byte on every item and keep data types in the body
	task automatic build_packet(input int n, input logic [2:0] end_kind, input bit tidy,
		input bit corrupt);
		logic [2:0] kind;
		bit has_b;
		bit last;
		int k;
		for (int i = 0; i < n; i++) begin
			last = (i == n - 1);
			kind = $urandom_range(0, 1) ? PKT_DATA : PKT_LAST_DATA;
			if (last) begin
				kind = end_kind;
			end else if (!tidy && $urandom_range(0, 7) == 0) begin
				k = $urandom_range(0, 2);
				kind = (k == 0) ? PKT_ACK : (k == 1) ? PKT_NACK :
					3'($urandom_range(PKT_RSVD_FIRST, PKT_RSVD_LAST));
			end
			has_b = tidy || $urandom_range(0, 9) != 0;
			if (last)
				queue_item(kind, has_b, 8'($urandom), 1'b1,
					corrupt ? (32'h1 << $urandom_range(0, 31)) : 32'h0, 1'b1);
			else
				queue_item(kind, has_b, 8'($urandom), 1'b0, $urandom, 1'b0);
		end
	endtask

	task automatic check_field(input string what, input logic [31:0] exp_v,
		input logic [31:0] got_v);
		if (got_v !== exp_v) begin
			errors++;
			$display("%0t mismatch on %s: expected %0d, actual %0d", $time, what, exp_v,
				got_v);
		end
	endtask

	// driver: predicts each accepted transaction, then offers the next pending item
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pkt_ch.valid <= 1'b0;
			pkt_ch.pkt_type <= PKT_DATA;
			pkt_ch.has_byte <= 1'b0;
			pkt_ch.byte_value <= '0;
			pkt_ch.end_of_packet <= 1'b0;
			pkt_ch.rx_checksum <= '0;
			send_gap = 0;
		end else begin
			if (pkt_ch.valid && pkt_ch.ready) begin
				seen_item.ptype = pkt_ch.pkt_type;
				seen_item.has_byte = pkt_ch.has_byte;
				seen_item.value = pkt_ch.byte_value;
				seen_item.eop = pkt_ch.end_of_packet;
				seen_item.rx = pkt_ch.rx_checksum;
				apply_packet_item(seen_item);
				items_in++;
			end
			if (!pkt_ch.valid || pkt_ch.ready) begin
				if (send_gap > 0) begin
					send_gap--;
					pkt_ch.valid <= 1'b0;
				end else if (outgoing_items.size() != 0) begin
					drv_item = outgoing_items.pop_front();
					pkt_ch.pkt_type <= drv_item.ptype;
					pkt_ch.has_byte <= drv_item.has_byte;
					pkt_ch.byte_value <= drv_item.value;
					pkt_ch.end_of_packet <= drv_item.eop;
					pkt_ch.rx_checksum <= drv_item.rx;
					pkt_ch.valid <= 1'b1;
					send_gap = pick_gap();
				end else begin
					pkt_ch.valid <= 1'b0;
				end
			end
		end
	end

	// monitor: checks each response transaction against the oldest expectation
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			rsp_stall = 0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (due_responses.size() == 0) begin
					errors++;
					$display("%0t response transaction with nothing expected", $time);
				end else begin
					want = due_responses.pop_front();
					check_field("response", 32'(want.resp), 32'(rsp_ch.response));
					check_field("commit", 32'(want.commit), 32'(rsp_ch.commit));
					check_field("message_done", 32'(want.done), 32'(rsp_ch.message_done));
					check_field("message_length", 32'(want.length),
						32'(rsp_ch.message_length));
					check_field("ack_notify", 32'(want.notify), 32'(rsp_ch.ack_notify));
					check_field("ack_value", 32'(want.ackv), 32'(rsp_ch.ack_value));
					check_field("link_alive", 32'(want.alive), 32'(rsp_ch.link_alive));
				end
				rsp_stall = pick_gap();
			end
			if (hold_rsp) begin
				rsp_ready_next = 1'b0;
			end else if (rsp_stall > 0) begin
				rsp_stall--;
				rsp_ready_next = 1'b0;
			end else begin
				rsp_ready_next = 1'b1;
			end
			rsp_ch.ready <= rsp_ready_next;
		end
	end

	// long receiver hold-off so the core fills up and drops its input ready
	initial begin
		hold_rsp = 1'b0;
		while (items_in < 300)
			@(posedge clk);
		hold_rsp <= 1'b1;
		repeat (80) @(posedge clk);
		hold_rsp <= 1'b0;
	end

	initial begin
		#2_000_000;
		$display("status: fail");
		$finish;
	end

	initial begin
		int pkt_idx;
		int start;
		int len;
		int k;
		arst_n = 1'b0;
		pkt_ch.valid = 1'b0;
		pkt_ch.pkt_type = PKT_DATA;
		pkt_ch.has_byte = 1'b0;
		pkt_ch.byte_value = '0;
		pkt_ch.end_of_packet = 1'b0;
		pkt_ch.rx_checksum = '0;
		rsp_ch.ready = 1'b0;
		errors = 0;
		items_in = 0;
		cyc = 0;
		gen_sum = '0;
		gen_pos = '0;
		clear_packet();
		msg_bytes = '0;
		link_up = 1'b1;

		// empty packets, good and bad
		queue_item(PKT_DATA, 1'b0, 8'h00, 1'b1, 32'h0, 1'b1);
		queue_item(PKT_DATA, 1'b0, 8'h00, 1'b1, 32'h1, 1'b1);
		// byte extremes over even and odd positions, ending the message
		queue_item(PKT_DATA, 1'b1, 8'h7f, 1'b0, 32'hdead_beef, 1'b0);
		queue_item(PKT_DATA, 1'b1, 8'h80, 1'b0, 32'h0, 1'b0);
		queue_item(PKT_LAST_DATA, 1'b1, 8'hff, 1'b1, 32'h0, 1'b1);
		queue_item(PKT_LAST_DATA, 1'b0, 8'h00, 1'b1, 32'h0, 1'b1);
		// notifications, bytes on them ignored
		queue_item(PKT_ACK, 1'b1, 8'h37, 1'b1, 32'hffff_ffff, 1'b0);
		queue_item(PKT_NACK, 1'b0, 8'h00, 1'b1, 32'h0, 1'b0);
		// unknown type on the end item clears what came before
		queue_item(PKT_DATA, 1'b1, 8'h05, 1'b0, 32'h0, 1'b0);
		queue_item(PKT_RSVD_FIRST, 1'b1, 8'h09, 1'b0, 32'h0, 1'b0);
		queue_item(PKT_RSVD_LAST, 1'b0, 8'h00, 1'b1, 32'h5, 1'b0);
		queue_item(PKT_DATA, 1'b0, 8'h00, 1'b1, 32'h0, 1'b1);
		// mixed types inside one packet
		queue_item(PKT_DATA, 1'b1, 8'hf9, 1'b0, 32'h0, 1'b0);
		queue_item(PKT_NACK, 1'b1, 8'h64, 1'b0, 32'h0, 1'b0);
		queue_item(PKT_ACK, 1'b1, 8'h03, 1'b0, 32'h0, 1'b0);
		queue_item(PKT_DATA, 1'b1, 8'h80, 1'b0, 32'h0, 1'b0);
		queue_item(PKT_LAST_DATA, 1'b1, 8'h7f, 1'b1, 32'h0, 1'b1);
		// checksum extremes
		queue_item(PKT_DATA, 1'b1, 8'h01, 1'b1, 32'h8000_0000, 1'b0);
		queue_item(PKT_DATA, 1'b0, 8'h00, 1'b1, 32'h7fff_ffff, 1'b0);
		queue_item(PKT_DATA, 1'b1, 8'hff, 1'b1, 32'h0, 1'b1);
		queue_item(PKT_LAST_DATA, 1'b1, 8'h80, 1'b1, 32'h8000_0000, 1'b1);

		start = outgoing_items.size();
		pkt_idx = 0;
		while (outgoing_items.size() - start < RANDOM_ITEMS) begin
			if (pkt_idx == 60) begin
				// overlong: the sum of the first MAX_PAYLOAD bytes still gets NACK
				build_packet(MAX_PAYLOAD + 1, PKT_DATA, 1'b1, 1'b0);
			end else if ($urandom_range(0, 99) < 8) begin
				len = $urandom_range(1, 6);
				for (int i = 0; i < len; i++) begin
					k = $urandom_range(0, 5);
					queue_item((k < 4) ? 3'(k) :
						3'($urandom_range(PKT_RSVD_FIRST, PKT_RSVD_LAST)),
						1'($urandom_range(0, 1)), 8'($urandom),
						(i == len - 1) || $urandom_range(0, 3) == 0, $urandom,
						1'($urandom_range(0, 1)));
				end
			end else begin
				len = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 8) :
					$urandom_range(9, 48);
				k = $urandom_range(0, 99);
				build_packet(len, (k < 45) ? PKT_DATA : (k < 72) ? PKT_LAST_DATA :
					(k < 84) ? PKT_ACK : (k < 95) ? PKT_NACK :
					3'($urandom_range(PKT_RSVD_FIRST, PKT_RSVD_LAST)),
					1'b0, $urandom_range(0, 4) == 0);
			end
			pkt_idx++;
		end

		// link goes down mid-packet, then every kind of item is ignored
		queue_item(PKT_DATA, 1'b1, 8'h2a, 1'b0, 32'h0, 1'b0);
		queue_item(PKT_TERM, 1'b0, 8'h00, 1'b0, 32'h0, 1'b0);
		queue_item(PKT_DATA, 1'b0, 8'h00, 1'b1, 32'h0, 1'b1);
		queue_item(PKT_LAST_DATA, 1'b1, 8'h11, 1'b1, 32'h11, 1'b0);
		queue_item(PKT_ACK, 1'b0, 8'h00, 1'b1, 32'h0, 1'b0);
		queue_item(PKT_NACK, 1'b1, 8'hff, 1'b1, 32'h0, 1'b0);
		queue_item(PKT_TERM, 1'b1, 8'h80, 1'b1, 32'h0, 1'b0);
		queue_item(PKT_RSVD_LAST, 1'b1, 8'h7f, 1'b1, 32'h0, 1'b0);

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		do
			@(negedge clk);
		while (outgoing_items.size() != 0 || pkt_ch.valid || due_responses.size() != 0);
		repeat (8) @(posedge clk);

		$display("covered %0d items: %0d acks, %0d nacks (%0d overlong), %0d messages done",
			items_in, n_ack, n_nack, n_overlong, n_done);
		$display("%0d ack/nack notifications, link taken down at the end", n_notify);
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

/* files.f */
rtl/core/swpr_pkg.sv
rtl/core/swpr_pkt_if.sv
rtl/core/swpr_rsp_if.sv
rtl/core/stop_and_wait_packet_receiver_core.sv
verif/tb.sv
